[rtl/i2a_pkg.sv]
// ----------------------------------------------------------------------------
// i2a_pkg
// shared widths, constants, command/status types and the digit character function
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int unsigned ValueW   = 32;
  localparam int unsigned BaseW    = 5;
  localparam int unsigned CountW   = 6;
  localparam int unsigned CharW    = 7;
  localparam int unsigned PosW     = 5;
  localparam int unsigned RemW     = 4;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 6;

  // long division of the magnitude, a byte of dividend bits per cycle
  localparam int unsigned StepBits = 8;
  localparam int unsigned DivSteps = ValueW / StepBits;
  localparam int unsigned StepCntW = $clog2(DivSteps);

  localparam logic [BaseW-1:0]  BaseReset  = 5'd10;
  localparam logic [BaseW-1:0]  BaseMin    = 5'd2;
  localparam logic [BaseW-1:0]  BaseMax    = 5'd16;
  localparam logic [BaseW-1:0]  BaseDec    = 5'd10;
  localparam logic [CountW-1:0] CountReset = 6'd10;
  localparam logic [CountW-1:0] CountMin   = 6'd1;
  localparam logic [CountW-1:0] CountMax   = 6'd32;

  localparam logic [CfgIdxW-1:0] CfgBase  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgCount = 1'b1;

  localparam logic [CharW-1:0] CharSpace = 7'h20;
  localparam logic [CharW-1:0] CharMinus = 7'h2D;
  localparam logic [CharW-1:0] CharZero  = 7'h30;
  localparam logic [CharW-1:0] CharAlpha = 7'h41;
  localparam logic [RemW-1:0]  DecDigits = 4'd10;

  typedef struct packed {
    logic load;        // take a new value
    logic step;        // one division step
    logic first_step;  // division starts with a clear remainder
    logic emit_digit;  // load the output with the digit of this step
    logic emit_fill;   // load the output with a space or minus
    logic advance;     // move one position to the left
  } i2a_cmd_t;

  typedef struct packed {
    logic need_div;    // the current position holds a digit
    logic last;        // the output holds position zero
  } i2a_status_t;

  function automatic logic [CharW-1:0] digit_char(input logic [RemW-1:0] d);
    logic [CharW-1:0] c;
    if (d < DecDigits) begin
      c = CharZero + {{(CharW-RemW){1'b0}}, d};
    end else begin
      c = CharAlpha + {{(CharW-RemW){1'b0}}, d - DecDigits};
    end
    return c;
  endfunction

endpackage

[rtl/i2a_dp.sv]
// ----------------------------------------------------------------------------
// i2a_dp
// datapath: config registers, magnitude divider, position and output register
// ----------------------------------------------------------------------------
module i2a_dp import i2a_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [ValueW-1:0]   value_i,
  input  i2a_cmd_t            cmd_i,
  output i2a_status_t         status_o,
  output logic [CharW-1:0]    character_o,
  output logic [PosW-1:0]     position_o,
  output logic                last_o
);

  logic [BaseW-1:0]  base_q;
  logic [CountW-1:0] count_q;
  logic [BaseW-1:0]  base_eff;
  logic [CountW-1:0] count_eff;

  logic [ValueW-1:0] mag_q, mag_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [CharW-1:0]  char_q, char_d;
  logic              sign_pend_q, sign_pend_d;
  logic              sign_now_q, sign_now_d;
  logic              first_q, first_d;

  logic [BaseW-1:0]    r;
  logic [StepBits-1:0] qbits;
  logic [ValueW-1:0]   mag_step;
  logic                neg;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BaseReset;
      count_q <= CountReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgBase:  base_q  <= cfg_data_i[BaseW-1:0];
        CfgCount: count_q <= cfg_data_i[CountW-1:0];
        default:  ;
      endcase
    end
  end

  assign base_eff  = (base_q < BaseMin) ? BaseMin :
                     (base_q > BaseMax) ? BaseMax : base_q;
  assign count_eff = (count_q < CountMin) ? CountMin :
                     (count_q > CountMax) ? CountMax : count_q;

  // one byte of restoring division by the base
  always_comb begin
    r     = cmd_i.first_step ? '0 : {1'b0, rem_q};
    qbits = '0;
    for (int i = 0; i < StepBits; i++) begin
      r = {r[RemW-1:0], mag_q[ValueW-1-i]};
      if (r >= base_eff) begin
        r = r - base_eff;
        qbits[StepBits-1-i] = 1'b1;
      end
    end
    mag_step = {mag_q[ValueW-StepBits-1:0], qbits};
  end

  assign neg = value_i[ValueW-1];

  always_comb begin
    mag_d       = mag_q;
    rem_d       = rem_q;
    pos_d       = pos_q;
    char_d      = char_q;
    sign_pend_d = sign_pend_q;
    sign_now_d  = sign_now_q;
    first_d     = first_q;
    if (cmd_i.load) begin
      mag_d       = neg ? (ValueW'(0) - value_i) : value_i;
      pos_d       = PosW'(count_eff - CountMin);
      sign_pend_d = neg && (base_eff == BaseDec);
      sign_now_d  = 1'b0;
      first_d     = 1'b1;
    end
    if (cmd_i.step) begin
      mag_d = mag_step;
      rem_d = r[RemW-1:0];
    end
    if (cmd_i.emit_digit) begin
      char_d  = digit_char(r[RemW-1:0]);
      first_d = 1'b0;
      if (mag_step == '0 && sign_pend_q) begin
        sign_pend_d = 1'b0;
        sign_now_d  = 1'b1;
      end
    end
    if (cmd_i.emit_fill) begin
      char_d     = sign_now_q ? CharMinus : CharSpace;
      sign_now_d = 1'b0;
    end
    if (cmd_i.advance) begin
      pos_d = pos_q - PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sign_pend_q <= 1'b0;
      sign_now_q  <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      sign_pend_q <= sign_pend_d;
      sign_now_q  <= sign_now_d;
      first_q     <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    rem_q  <= rem_d;
    pos_q  <= pos_d;
    char_q <= char_d;
  end

  assign status_o.need_div = !sign_now_q && (first_q || (mag_q != '0));
  assign status_o.last     = (pos_q == '0);

  assign character_o = char_q;
  assign position_o  = pos_q;
  assign last_o      = (pos_q == '0);

endmodule

[rtl/i2a_ctrl.sv]
// ----------------------------------------------------------------------------
// i2a_ctrl
// controller: sequences load, division steps and output handshakes
// ----------------------------------------------------------------------------
module i2a_ctrl import i2a_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  i2a_status_t status_i,
  output i2a_cmd_t    cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  localparam logic [StepCntW-1:0] LastStep = StepCntW'(DivSteps - 1);

  logic [1:0]          state_q, state_d;
  logic [StepCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = StDiv;
        end
      end
      StDiv: begin
        // magnitude is only whole before the first step of a position
        if (cnt_q == '0 && !status_i.need_div) begin
          cmd_o.emit_fill = 1'b1;
          state_d         = StOut;
        end else begin
          cmd_o.step       = 1'b1;
          cmd_o.first_step = (cnt_q == '0);
          cnt_d            = cnt_q + StepCntW'(1);
          if (cnt_q == LastStep) begin
            cmd_o.emit_digit = 1'b1;
            state_d          = StOut;
          end
        end
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (status_i.last) begin
            state_d = StIdle;
          end else begin
            cmd_o.advance = 1'b1;
            cnt_d         = '0;
            state_d       = StDiv;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

[rtl/integer_to_ascii_radix_top.sv]
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_top
// renders a signed 32-bit value as a right-justified ascii field in base 2..16
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  ---------------------------
//  in        request    in_valid_i / in_ready_o   value_i
//  out       result     out_valid_o / out_ready_i character_o, position_o,
//                                                 last_o
//  cfg       write      cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
//  one request gives digit_count results, rightmost position first
//  a digit position runs the byte-wide divider steps, then the output handshake;
//  a space or minus position loads its fill, then the output handshake
//  reset: base 10, field width 10, controller idle
//  a stalled result holds the block; the next request is taken after the last
//
module integer_to_ascii_radix_top import i2a_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [ValueW-1:0]   value_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [CharW-1:0]    character_o,
  output logic [PosW-1:0]     position_o,
  output logic                last_o
);

  // commands from controller to datapath, status back
  i2a_cmd_t    cmd;
  i2a_status_t status;

  // sequencer: idle, divide steps, result handshake
  i2a_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // config registers, magnitude, divider, sign tracking, output register
  i2a_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .character_o (character_o),
    .position_o  (position_o),
    .last_o      (last_o)
  );

`ifndef SYNTHESIS
  // never accepting a request while a result is shown
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("request taken while result pending");

  // the leftmost result ends the run and frees the input
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o) |=> in_ready_o)
    else $error("no return to idle after last result");

  // a result that is not the last keeps the run going
  a_run_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> !in_ready_o)
    else $error("run ended before leftmost position");

  // a new request is never answered in the next cycle
  a_load_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o)
    else $error("result shown right after request");
`endif

endmodule

[tb/sv/i2a_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_checker
// watches the config, request and result channels of the radix renderer,
// predicts each character of the field and compares it on arrival
// ----------------------------------------------------------------------------
module i2a_checker import i2a_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [ValueW-1:0]   value_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [CharW-1:0]    character_i,
  input  logic [PosW-1:0]     position_i,
  input  logic                last_i,
  output int                  pending_o,
  output int                  fail_count_o,
  output int                  chars_checked_o
);

  localparam int unsigned FieldLimit = 32;

  typedef struct packed {
    logic [CharW-1:0] character;
    logic [PosW-1:0]  position;
    logic             last;
  } field_char_t;

  logic [BaseW-1:0]  base_q;
  logic [CountW-1:0] count_q;
  field_char_t       field_chars_q[$];
  field_char_t       want;

  initial begin
    fail_count_o    = 0;
    chars_checked_o = 0;
  end

  task automatic report_fault(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic void queue_char(input logic [CharW-1:0] ch, input int unsigned pos);
    field_char_t c;
    c.character = ch;
    c.position  = pos[PosW-1:0];
    c.last      = (pos == 0);
    field_chars_q.push_back(c);
  endfunction

  // characters of one right-justified field, rightmost position first
  function automatic void render_field(input logic [ValueW-1:0] raw);
    logic [ValueW-1:0] mag;
    logic [RemW-1:0]   d;
    logic [CharW-1:0]  ch;
    logic              sign_pending;
    int unsigned       b;
    int unsigned       n;
    int unsigned       k;
    mag = raw[ValueW-1] ? (~raw + 1'b1) : raw;
    b = 32'(base_q);
    if (b < 32'(BaseMin)) b = 32'(BaseMin);
    if (b > 32'(BaseMax)) b = 32'(BaseMax);
    n = 32'(count_q);
    if (n < 32'(CountMin)) n = 32'(CountMin);
    if (n > FieldLimit) n = FieldLimit;
    sign_pending = raw[ValueW-1] && (b == 32'(BaseDec));
    k = 0;
    while (k < n) begin
      if (mag == 0 && k > 0) begin
        ch = CharSpace;
      end else begin
        d  = RemW'(mag % b);
        ch = (d < DecDigits) ? CharZero + CharW'(d) : CharAlpha + CharW'(d - DecDigits);
      end
      queue_char(ch, n - 1 - k);
      mag = mag / b;
      // minus goes just left of the top digit, dropped when the field is full
      if (mag == 0 && sign_pending) begin
        sign_pending = 1'b0;
        k++;
        if (k < n) queue_char(CharMinus, n - 1 - k);
      end
      k++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BaseReset;
      count_q <= CountReset;
      field_chars_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgBase:  base_q  <= cfg_data_i[BaseW-1:0];
          CfgCount: count_q <= cfg_data_i;
          default:  ;
        endcase
      end
      if (in_valid_i && in_ready_i) render_field(value_i);
      if (out_valid_i && out_ready_i) begin
        if (field_chars_q.size() == 0) begin
          report_fault($sformatf("unexpected char %h at position %0d last %b",
                                 character_i, position_i, last_i));
        end else begin
          want = field_chars_q.pop_front();
          chars_checked_o++;
          if (character_i !== want.character || position_i !== want.position ||
              last_i !== want.last) begin
            report_fault($sformatf("got char %h pos %0d last %b, want char %h pos %0d last %b",
                                   character_i, position_i, last_i,
                                   want.character, want.position, want.last));
          end
        end
      end
      pending_o <= field_chars_q.size();
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives the radix renderer with directed and random values under many
// base/width settings, with random gaps on both channels; the checker beside
// the block predicts every character and counts mismatches
// ----------------------------------------------------------------------------
module tb_top;
  import i2a_pkg::*;

  // worst case 32 positions per request
  localparam int unsigned DrainCycles  = 200;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned PhaseItems   = 45;
  localparam int unsigned RandPhases   = 5;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = CfgBase;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic [ValueW-1:0]   value     = '0;
  logic                out_ready = 1'b0;

  logic                in_ready;
  logic                out_valid;
  logic [CharW-1:0]    character;
  logic [PosW-1:0]     position;
  logic                last;

  int pending;
  int fail_count;
  int chars_checked;

  // no idling on either side while set
  bit          calm         = 1'b0;
  int unsigned values_sent  = 0;
  int unsigned formats_used = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  integer_to_ascii_radix_top u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .value_i     (value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .character_o (character),
    .position_o  (position),
    .last_o      (last)
  );

  i2a_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .value_i         (value),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .character_i     (character),
    .position_i      (position),
    .last_i          (last),
    .pending_o       (pending),
    .fail_count_o    (fail_count),
    .chars_checked_o (chars_checked)
  );

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // values mixing full-range noise, small magnitudes and the extremes
  function automatic logic [ValueW-1:0] random_value();
    logic [ValueW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 300);
      2: begin
        v = $urandom_range(1, 300);
        v = -v;
      end
      3: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      4: begin
        v = $urandom() >> $urandom_range(0, 31);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // result side: random stalls unless in a calm stretch
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  // one request; valid is left high after acceptance so back-to-back
  // requests never lower and raise it in the same step
  task automatic send_value(input logic [ValueW-1:0] v);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    values_sent++;
  endtask

  // stop sending and wait until every predicted character has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // writes both registers back to back, only while the block is idle
  task automatic set_format(input logic [CfgDataW-1:0] base_val,
                            input logic [CfgDataW-1:0] count_val);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgBase;
    cfg_data <= base_val;
    @(posedge clk);
    cfg_idx  <= CfgCount;
    cfg_data <= count_val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    formats_used++;
  endtask

  // run limit, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("timeout with %0d characters still expected", pending);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int unsigned calm_from;
    logic [CfgDataW-1:0] b_val;
    logic [CfgDataW-1:0] n_val;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset format, base 10 width 10: zero, signs, extremes, sign placement
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd123456789);
    send_value(-32'sd123456789);   // minus lands on position 0
    send_value(-32'sd1234567890);  // digits fill the field, minus dropped
    settle();

    // hex, 8 wide: magnitude only, no sign
    set_format(6'd16, 6'd8);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'hDEAD_BEEF);
    settle();

    // binary across the whole 32-position field
    set_format(6'd2, 6'd32);
    send_value(32'h8000_0000);
    send_value(32'h5555_5555);
    send_value(32'd0);
    settle();

    // base below two and zero width are clamped up
    set_format(6'd1, 6'd0);
    send_value(32'd5);
    send_value(32'd0);
    settle();

    // base above sixteen and width above the limit are clamped down
    set_format(6'd31, 6'd63);
    send_value(32'hABCD_EF12);
    settle();

    // one-wide decimal: minus has no room
    set_format(6'd10, 6'd1);
    send_value(-32'sd7);
    send_value(32'd3);
    settle();

    // two-wide decimal: minus just fits, or is dropped
    set_format(6'd10, 6'd2);
    send_value(-32'sd7);
    send_value(-32'sd10);
    settle();

    // odd base with a negative value shows magnitude only
    set_format(6'd3, 6'd5);
    send_value(-32'sd100);
    settle();

    // upper data bit of the base write is dropped, 42 reads as 10
    set_format(6'd42, 6'd40);
    send_value(32'h8000_0000);
    settle();

    // random phases, each under its own format
    for (int p = 0; p < RandPhases; p++) begin
      case (p)
        0: begin
          b_val = 6'd2;
          n_val = 6'd32;
        end
        1: begin
          b_val = 6'd16;
          n_val = 6'd1;
        end
        2: begin
          b_val = 6'd10;
          n_val = CfgDataW'($urandom_range(1, 12));
        end
        default: begin
          b_val = ($urandom_range(0, 3) == 0) ? CfgDataW'($urandom_range(0, 63)) :
                                                CfgDataW'($urandom_range(2, 16));
          n_val = ($urandom_range(0, 4) == 0) ? CfgDataW'($urandom_range(32, 63)) :
                                                CfgDataW'($urandom_range(1, 12));
        end
      endcase
      set_format(b_val, n_val);
      calm_from = $urandom_range(0, PhaseItems - 15);
      for (int i = 0; i < PhaseItems; i++) begin
        calm = (i >= calm_from) && (i < calm_from + 15);
        send_value(random_value());
        // now and then let the result side drain completely mid-phase
        if ($urandom_range(0, 24) == 0) settle();
      end
      calm = 1'b0;
      settle();
    end

    // everything sent: wait for the last characters, then watch for strays
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("summary: %0d values rendered under %0d base/width settings",
             values_sent, formats_used);
    $display("summary: %0d characters compared, %0d mismatches",
             chars_checked, fail_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/i2a_pkg.sv
rtl/i2a_dp.sv
rtl/i2a_ctrl.sv
rtl/integer_to_ascii_radix_top.sv
tb/sv/i2a_checker.sv
tb/sv/tb_top.sv
